>>> hdl/qmr_pkg.sv
// Shared types, constants and helpers for the quaternion multiply/rotate core.
// Used by the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qmr_pkg;

   // Fixed-point format: Q3.12 in 16 bits
   localparam int DATA_W = 16;
   localparam int FRAC_W = 12;

   // Datapath widths
   localparam int PROD_W  = 2 * DATA_W;        // a * q product
   localparam int T_W     = PROD_W + 2;        // sum of four products
   localparam int CONJ_W  = DATA_W + 1;        // negated a component
   localparam int PROD2_W = T_W + CONJ_W;      // t * conj(a) product
   localparam int WIDE_W  = PROD2_W + 2;       // sum of four wide products
   localparam int RND_W   = WIDE_W + 1;        // room for the rounding offset
   localparam int CLAMP_W = RND_W - 2 * FRAC_W; // widest value after the shift

   // Action codes
   localparam logic [1:0] ACT_MULTIPLY  = 2'd0;
   localparam logic [1:0] ACT_ROTATE    = 2'd1;
   localparam logic [1:0] ACT_CONJUGATE = 2'd2;

   // Rounding offsets (half an LSB of the result)
   localparam logic signed [RND_W-1:0] HALF_MUL = RND_W'(1) <<< (FRAC_W - 1);
   localparam logic signed [RND_W-1:0] HALF_ROT = RND_W'(1) <<< (2 * FRAC_W - 1);

   // Output range in the clamp width
   localparam logic signed [CLAMP_W-1:0] Q_MAX = CLAMP_W'(32767);
   localparam logic signed [CLAMP_W-1:0] Q_MIN = CLAMP_W'(-32768);

   typedef struct packed {
      logic [1:0]               action;
      logic signed [DATA_W-1:0] a_w;
      logic signed [DATA_W-1:0] a_x;
      logic signed [DATA_W-1:0] a_y;
      logic signed [DATA_W-1:0] a_z;
      logic signed [DATA_W-1:0] b_w;
      logic signed [DATA_W-1:0] b_x;
      logic signed [DATA_W-1:0] b_y;
      logic signed [DATA_W-1:0] b_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] r_w;
      logic signed [DATA_W-1:0] r_x;
      logic signed [DATA_W-1:0] r_y;
      logic signed [DATA_W-1:0] r_z;
      logic                     saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic                     flag;
      logic signed [DATA_W-1:0] value;
   } clamp_type;

   // Clamp a rounded value to the 16-bit range, flag when clipped
   function automatic clamp_type clamp16(input logic signed [CLAMP_W-1:0] v);
      clamp_type res;
      if (v > Q_MAX) begin
         res.flag  = 1'b1;
         res.value = Q_MAX[DATA_W-1:0];
      end else if (v < Q_MIN) begin
         res.flag  = 1'b1;
         res.value = Q_MIN[DATA_W-1:0];
      end else begin
         res.flag  = 1'b0;
         res.value = v[DATA_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> hdl/qmr_stream_if.sv
// Valid/ready stream interface carrying one payload beat per handshake.
// Payload type is set per instance; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

interface qmr_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/quaternion_multiply_rotate_core.sv
// Throughput: one beat per cycle while rsp_ch is ready; five pipeline stages, each
// with its own valid bit, so bubbles collapse and a stalled rsp holds each full
// stage with no empty stage between it and the output.
// Reset clears the stage valid bits only; the unit keeps no other state.
// Uses qmr_pkg and qmr_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_multiply_rotate_core (
   input  wire logic        clock,
   input  wire logic        reset,
   qmr_stream_if.sink       req_ch,
   qmr_stream_if.source     rsp_ch
);

   localparam int DW  = qmr_pkg::DATA_W;
   localparam int PW  = qmr_pkg::PROD_W;
   localparam int TW  = qmr_pkg::T_W;
   localparam int CW  = qmr_pkg::CONJ_W;
   localparam int P2W = qmr_pkg::PROD2_W;
   localparam int WW  = qmr_pkg::WIDE_W;
   localparam int RW  = qmr_pkg::RND_W;
   localparam int KW  = qmr_pkg::CLAMP_W;

   // Per-stage ready: a stage loads when empty or when the next one loads
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;

   assign rdy5 = !s5_valid_ff || rsp_ch.ready;
   assign rdy4 = !s4_valid_ff || rdy5;
   assign rdy3 = !s3_valid_ff || rdy4;
   assign rdy2 = !s2_valid_ff || rdy3;
   assign rdy1 = !s1_valid_ff || rdy2;
   assign req_ch.ready = rdy1;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff <= req_ch.valid;
         if (rdy2) s2_valid_ff <= s1_valid_ff;
         if (rdy3) s3_valid_ff <= s2_valid_ff;
         if (rdy4) s4_valid_ff <= s3_valid_ff;
         if (rdy5) s5_valid_ff <= s4_valid_ff;
      end
   end

   // ---------------- Stage 1: products a[i] * q[j] ----------------
   logic signed [DW-1:0] a_in [4];
   logic signed [DW-1:0] q_in [4];
   logic signed [PW-1:0] prod1_in [4][4];

   logic [1:0]           s1_action_ff;
   logic signed [DW-1:0] s1_a_ff [4];
   logic signed [PW-1:0] s1_prod_ff [4][4];

   always_comb begin
      a_in[0] = req_ch.payload.a_w;
      a_in[1] = req_ch.payload.a_x;
      a_in[2] = req_ch.payload.a_y;
      a_in[3] = req_ch.payload.a_z;
      // rotation uses the pure vector (0, b_x, b_y, b_z)
      q_in[0] = (req_ch.payload.action == qmr_pkg::ACT_ROTATE) ? '0 : req_ch.payload.b_w;
      q_in[1] = req_ch.payload.b_x;
      q_in[2] = req_ch.payload.b_y;
      q_in[3] = req_ch.payload.b_z;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            prod1_in[i][j] = PW'(a_in[i]) * PW'(q_in[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_action_ff <= req_ch.payload.action;
         s1_a_ff      <= a_in;
         s1_prod_ff   <= prod1_in;
      end
   end

   // ---------------- Stage 2: Hamilton sums t = a * q ----------------
   logic signed [TW-1:0] t_in [4];

   logic [1:0]           s2_action_ff;
   logic signed [DW-1:0] s2_a_ff [4];
   logic signed [TW-1:0] s2_t_ff [4];

   always_comb begin
      t_in[0] = TW'(s1_prod_ff[0][0]) - TW'(s1_prod_ff[1][1])
              - TW'(s1_prod_ff[2][2]) - TW'(s1_prod_ff[3][3]);
      t_in[1] = TW'(s1_prod_ff[0][1]) + TW'(s1_prod_ff[1][0])
              + TW'(s1_prod_ff[2][3]) - TW'(s1_prod_ff[3][2]);
      t_in[2] = TW'(s1_prod_ff[0][2]) - TW'(s1_prod_ff[1][3])
              + TW'(s1_prod_ff[2][0]) + TW'(s1_prod_ff[3][1]);
      t_in[3] = TW'(s1_prod_ff[0][3]) + TW'(s1_prod_ff[1][2])
              - TW'(s1_prod_ff[2][1]) + TW'(s1_prod_ff[3][0]);
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_action_ff <= s1_action_ff;
         s2_a_ff      <= s1_a_ff;
         s2_t_ff      <= t_in;
      end
   end

   // ---------------- Stage 3: products t[i] * conj(a)[j] ----------------
   logic signed [CW-1:0]  c_in [4];
   logic signed [P2W-1:0] prod2_in [4][4];

   logic [1:0]            s3_action_ff;
   logic signed [DW-1:0]  s3_a_ff [4];
   logic signed [TW-1:0]  s3_t_ff [4];
   logic signed [P2W-1:0] s3_prod_ff [4][4];

   always_comb begin
      c_in[0] = CW'(s2_a_ff[0]);
      for (int j = 1; j < 4; j++) begin
         c_in[j] = -CW'(s2_a_ff[j]);
      end
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            prod2_in[i][j] = P2W'(s2_t_ff[i]) * P2W'(c_in[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_action_ff <= s2_action_ff;
         s3_a_ff      <= s2_a_ff;
         s3_t_ff      <= s2_t_ff;
         s3_prod_ff   <= prod2_in;
      end
   end

   // ---------------- Stage 4: Hamilton sums p = t * conj(a), select ----------------
   logic signed [WW-1:0] p_in [4];
   logic signed [WW-1:0] wide_in [4];

   logic [1:0]           s4_action_ff;
   logic signed [DW-1:0] s4_a_ff [4];
   logic signed [WW-1:0] s4_wide_ff [4];

   always_comb begin
      p_in[0] = WW'(s3_prod_ff[0][0]) - WW'(s3_prod_ff[1][1])
              - WW'(s3_prod_ff[2][2]) - WW'(s3_prod_ff[3][3]);
      p_in[1] = WW'(s3_prod_ff[0][1]) + WW'(s3_prod_ff[1][0])
              + WW'(s3_prod_ff[2][3]) - WW'(s3_prod_ff[3][2]);
      p_in[2] = WW'(s3_prod_ff[0][2]) - WW'(s3_prod_ff[1][3])
              + WW'(s3_prod_ff[2][0]) + WW'(s3_prod_ff[3][1]);
      p_in[3] = WW'(s3_prod_ff[0][3]) + WW'(s3_prod_ff[1][2])
              - WW'(s3_prod_ff[2][1]) + WW'(s3_prod_ff[3][0]);
      // keep the double product for rotation, the single one otherwise
      for (int i = 0; i < 4; i++) begin
         wide_in[i] = (s3_action_ff == qmr_pkg::ACT_ROTATE) ? p_in[i] : WW'(s3_t_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_action_ff <= s3_action_ff;
         s4_a_ff      <= s3_a_ff;
         s4_wide_ff   <= wide_in;
      end
   end

   // ---------------- Stage 5: round, clamp, output register ----------------
   logic signed [RW-1:0] mul_sum [4];
   logic signed [RW-1:0] rot_sum [4];
   logic signed [RW-1:0] mul_shift [4];
   logic signed [RW-1:0] rot_shift [4];
   logic signed [CW-1:0] neg_a [4];
   logic signed [KW-1:0] pre_clamp [4];
   qmr_pkg::clamp_type   clamped [4];
   logic signed [DW-1:0] res [4];
   logic                 sat;
   qmr_pkg::rsp_payload_type out_in;
   qmr_pkg::rsp_payload_type s5_out_ff;

   always_comb begin
      sat = 1'b0;
      for (int i = 0; i < 4; i++) begin
         mul_sum[i]   = RW'(s4_wide_ff[i]) + qmr_pkg::HALF_MUL;
         rot_sum[i]   = RW'(s4_wide_ff[i]) + qmr_pkg::HALF_ROT;
         mul_shift[i] = mul_sum[i] >>> qmr_pkg::FRAC_W;
         rot_shift[i] = rot_sum[i] >>> (2 * qmr_pkg::FRAC_W);
         neg_a[i]     = -CW'(s4_a_ff[i]);
         case (s4_action_ff)
            qmr_pkg::ACT_MULTIPLY:  pre_clamp[i] = mul_shift[i][KW-1:0];
            qmr_pkg::ACT_ROTATE:    pre_clamp[i] = rot_shift[i][KW-1:0];
            qmr_pkg::ACT_CONJUGATE: pre_clamp[i] = KW'(neg_a[i]);
            default:                pre_clamp[i] = '0;
         endcase
         clamped[i] = qmr_pkg::clamp16(pre_clamp[i]);
         res[i]     = clamped[i].value;
      end
      // scalar part: conjugate passes a_w, rotation forces zero
      if (s4_action_ff == qmr_pkg::ACT_CONJUGATE) begin
         res[0] = s4_a_ff[0];
      end else if (s4_action_ff == qmr_pkg::ACT_ROTATE) begin
         res[0] = '0;
      end else begin
         sat = clamped[0].flag;
      end
      sat = sat | clamped[1].flag | clamped[2].flag | clamped[3].flag;
      out_in.r_w       = res[0];
      out_in.r_x       = res[1];
      out_in.r_y       = res[2];
      out_in.r_z       = res[3];
      out_in.saturated = sat;
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         s5_out_ff <= out_in;
      end
   end

   assign rsp_ch.valid   = s5_valid_ff;
   assign rsp_ch.payload = s5_out_ff;

endmodule

`default_nettype wire
